[sv/sae_pkg.sv]
// Shared types, constants and controller states for the suffix automaton engine.
// Used by sae_core and suffix_automaton_lcs_engine_unit.
package sae_pkg;

  localparam int DEF_MAX_TEXT    = 1024;
  localparam int DEF_SYMBOL_BITS = 8;
  localparam int EPOCH_BITS      = 4;

  localparam logic KIND_EXTEND = 1'b0;
  localparam logic KIND_MATCH  = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] symbol;
    logic       first;
  } sae_in_t;

  typedef struct packed {
    logic [19:0] distinct_count;
    logic [11:0] states_used;
    logic [10:0] match_len;
    logic [10:0] best_len;
    logic [15:0] best_end;
    logic        overflow;
  } sae_out_t;

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001,
    S_CLEAR = 16'h0002,
    S_GL    = 16'h0004,
    S_WT    = 16'h0008,
    S_WL    = 16'h0010,
    S_FP    = 16'h0020,
    S_FQ    = 16'h0040,
    S_CP    = 16'h0080,
    S_RT    = 16'h0100,
    S_RL    = 16'h0200,
    S_QW    = 16'h0400,
    S_FIN   = 16'h0800,
    S_MT    = 16'h1000,
    S_ML    = 16'h2000,
    S_MLEN  = 16'h4000,
    S_OUT   = 16'h8000
  } sae_state_t;

endpackage

[sv/sae_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Same-address read during write returns the written data. No dependencies.
module sae_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (we && (waddr == raddr)) begin
      rdata_r <= wdata;
    end else begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[sv/sae_core.sv]
// Automaton builder and matcher: sequencer over the node and transition memories.
// Depends on sae_pkg and sae_ram.
module sae_core #(
  parameter int MAX_TEXT    = sae_pkg::DEF_MAX_TEXT,
  parameter int SYMBOL_BITS = sae_pkg::DEF_SYMBOL_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sae_pkg::sae_in_t  in_data,
  output logic              res_valid,
  input  logic              res_take,
  output sae_pkg::sae_out_t res_data
);
  import sae_pkg::*;

  localparam int SB  = SYMBOL_BITS;
  localparam int SW  = $clog2(2 * MAX_TEXT);
  localparam int LW  = $clog2(MAX_TEXT + 1);
  localparam int EB  = EPOCH_BITS;
  localparam int TAW = SW + SB;
  localparam int TDW = EB + SW;
  localparam int NDW = LW + SW;

  sae_state_t state_r, state_nxt;
  logic [EB-1:0]  epoch_r, epoch_nxt;
  logic [TAW-1:0] clr_r, clr_nxt;
  logic           resume_r, resume_nxt;
  logic [SB-1:0]  sym_r, sym_nxt;
  logic [SW-1:0]  cnt_r, cnt_nxt;
  logic [SW-1:0]  last_r, last_nxt;
  logic [LW-1:0]  tlen_r, tlen_nxt;
  logic [19:0]    dist_r, dist_nxt;
  logic [SW-1:0]  ms_r, ms_nxt;
  logic [LW-1:0]  cm_r, cm_nxt;
  logic [LW-1:0]  best_r, best_nxt;
  logic [15:0]    bpos_r, bpos_nxt;
  logic [15:0]    mpos_r, mpos_nxt;
  logic           sat_r, sat_nxt;
  logic           ovf_r, ovf_nxt;

  logic [SW-1:0]  p_r, p_nxt;
  logic [SW-1:0]  cur_r, cur_nxt;
  logic [SW-1:0]  cl_r, cl_nxt;
  logic [SW-1:0]  q_r, q_nxt;
  logic [LW-1:0]  len_cur_r, len_cur_nxt;
  logic [LW-1:0]  len_p_r, len_p_nxt;
  logic [LW-1:0]  len_q_r, len_q_nxt;
  logic [SW-1:0]  link_cur_r, link_cur_nxt;
  logic [LW-1:0]  link_len_r, link_len_nxt;
  logic [SB:0]    k_r, k_nxt;

  logic           t_we;
  logic [TAW-1:0] t_waddr, t_raddr;
  logic [TDW-1:0] t_wdata, t_rdata;
  logic           n_we;
  logic [SW-1:0]  n_waddr, n_raddr;
  logic [NDW-1:0] n_wdata, n_rdata;

  logic           tv;
  logic [SW-1:0]  tt;
  logic [LW-1:0]  nlen;
  logic [SW-1:0]  nlink;
  logic [SB:0]    km1;
  logic [LW-1:0]  cmn;

  sae_ram #(.WIDTH(TDW), .DEPTH(2 ** TAW)) u_trans (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .raddr(t_raddr), .rdata(t_rdata)
  );

  sae_ram #(.WIDTH(NDW), .DEPTH(2 ** SW)) u_node (
    .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
    .raddr(n_raddr), .rdata(n_rdata)
  );

  assign tv    = (t_rdata[TDW-1:SW] == epoch_r);
  assign tt    = t_rdata[SW-1:0];
  assign nlen  = n_rdata[NDW-1:SW];
  assign nlink = n_rdata[SW-1:0];
  assign km1   = k_r - 1'b1;

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_OUT);

  always_comb begin
    res_data.distinct_count = dist_r;
    res_data.states_used    = 12'(cnt_r);
    res_data.match_len      = 11'(cm_r);
    res_data.best_len       = 11'(best_r);
    res_data.best_end       = bpos_r;
    res_data.overflow       = ovf_r;
  end

  always_comb begin
    state_nxt    = state_r;
    epoch_nxt    = epoch_r;
    clr_nxt      = clr_r;
    resume_nxt   = resume_r;
    sym_nxt      = sym_r;
    cnt_nxt      = cnt_r;
    last_nxt     = last_r;
    tlen_nxt     = tlen_r;
    dist_nxt     = dist_r;
    ms_nxt       = ms_r;
    cm_nxt       = cm_r;
    best_nxt     = best_r;
    bpos_nxt     = bpos_r;
    mpos_nxt     = mpos_r;
    sat_nxt      = sat_r;
    ovf_nxt      = ovf_r;
    p_nxt        = p_r;
    cur_nxt      = cur_r;
    cl_nxt       = cl_r;
    q_nxt        = q_r;
    len_cur_nxt  = len_cur_r;
    len_p_nxt    = len_p_r;
    len_q_nxt    = len_q_r;
    link_cur_nxt = link_cur_r;
    link_len_nxt = link_len_r;
    k_nxt        = k_r;
    cmn          = cm_r;
    t_we         = 1'b0;
    t_waddr      = {p_r, sym_r};
    t_wdata      = {epoch_r, cur_r};
    t_raddr      = {p_r, sym_r};
    n_we         = 1'b0;
    n_waddr      = cur_r;
    n_wdata      = {len_cur_r, link_cur_r};
    n_raddr      = p_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          sym_nxt = in_data.symbol[SB-1:0];
          if (in_data.kind == KIND_EXTEND) begin
            ovf_nxt = 1'b0;
            if (in_data.first) begin
              cnt_nxt  = SW'(1);
              last_nxt = '0;
              tlen_nxt = '0;
              dist_nxt = '0;
              ms_nxt   = '0;
              cm_nxt   = '0;
              best_nxt = '0;
              bpos_nxt = '0;
              mpos_nxt = '0;
              sat_nxt  = 1'b0;
              if (epoch_r == {EB{1'b1}}) begin
                resume_nxt = 1'b1;
                clr_nxt    = '0;
                state_nxt  = S_CLEAR;
              end else begin
                epoch_nxt = epoch_r + 1'b1;
                n_we      = 1'b1;
                n_waddr   = '0;
                n_wdata   = '0;
                n_raddr   = '0;
                state_nxt = S_GL;
              end
            end else if (tlen_r >= LW'(MAX_TEXT)) begin
              ovf_nxt   = 1'b1;
              state_nxt = S_OUT;
            end else begin
              n_raddr   = last_r;
              state_nxt = S_GL;
            end
          end else begin
            if (in_data.first) begin
              ms_nxt   = '0;
              cm_nxt   = '0;
              best_nxt = '0;
              bpos_nxt = '0;
              mpos_nxt = '0;
              sat_nxt  = 1'b0;
              ovf_nxt  = 1'b0;
              t_raddr  = {{SW{1'b0}}, in_data.symbol[SB-1:0]};
            end else begin
              ovf_nxt  = sat_r;
              t_raddr  = {ms_r, in_data.symbol[SB-1:0]};
            end
            state_nxt = S_MT;
          end
        end
      end
      S_CLEAR: begin
        t_we    = 1'b1;
        t_waddr = clr_r;
        t_wdata = '0;
        n_we    = 1'b1;
        n_waddr = clr_r[SW-1:0];
        n_wdata = '0;
        n_raddr = '0;
        if (clr_r == {TAW{1'b1}}) begin
          epoch_nxt = EB'(1);
          if (resume_r) begin
            resume_nxt = 1'b0;
            state_nxt  = S_GL;
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end
      S_GL: begin
        len_cur_nxt = nlen + 1'b1;
        cur_nxt     = cnt_r;
        cnt_nxt     = cnt_r + 1'b1;
        p_nxt       = last_r;
        t_raddr     = {last_r, sym_r};
        state_nxt   = S_WT;
      end
      S_WT: begin
        if (tv) begin
          q_nxt     = tt;
          n_raddr   = p_r;
          state_nxt = S_FP;
        end else begin
          t_we = 1'b1;
          if (p_r == '0) begin
            link_cur_nxt = '0;
            link_len_nxt = '0;
            state_nxt    = S_FIN;
          end else begin
            n_raddr   = p_r;
            state_nxt = S_WL;
          end
        end
      end
      S_WL: begin
        p_nxt     = nlink;
        t_raddr   = {nlink, sym_r};
        state_nxt = S_WT;
      end
      S_FP: begin
        len_p_nxt = nlen;
        n_raddr   = q_r;
        state_nxt = S_FQ;
      end
      S_FQ: begin
        len_q_nxt = nlen;
        if (LW'(len_p_r + 1'b1) == nlen) begin
          link_cur_nxt = q_r;
          link_len_nxt = nlen;
          state_nxt    = S_FIN;
        end else begin
          cl_nxt    = cnt_r;
          cnt_nxt   = cnt_r + 1'b1;
          n_we      = 1'b1;
          n_waddr   = cnt_r;
          n_wdata   = {LW'(len_p_r + 1'b1), nlink};
          k_nxt     = '0;
          state_nxt = S_CP;
        end
      end
      S_CP: begin
        if (k_r[SB]) begin
          t_raddr   = {p_r, sym_r};
          state_nxt = S_RT;
        end else begin
          t_raddr = {q_r, k_r[SB-1:0]};
          k_nxt   = k_r + 1'b1;
        end
        if (k_r != '0) begin
          t_we    = 1'b1;
          t_waddr = {cl_r, km1[SB-1:0]};
          t_wdata = t_rdata;
        end
      end
      S_RT: begin
        if (tv && (tt == q_r)) begin
          t_we    = 1'b1;
          t_wdata = {epoch_r, cl_r};
          if (p_r == '0) begin
            state_nxt = S_QW;
          end else begin
            n_raddr   = p_r;
            state_nxt = S_RL;
          end
        end else begin
          state_nxt = S_QW;
        end
      end
      S_RL: begin
        p_nxt     = nlink;
        t_raddr   = {nlink, sym_r};
        state_nxt = S_RT;
      end
      S_QW: begin
        n_we         = 1'b1;
        n_waddr      = q_r;
        n_wdata      = {len_q_r, cl_r};
        link_cur_nxt = cl_r;
        link_len_nxt = LW'(len_p_r + 1'b1);
        state_nxt    = S_FIN;
      end
      S_FIN: begin
        n_we      = 1'b1;
        last_nxt  = cur_r;
        tlen_nxt  = tlen_r + 1'b1;
        dist_nxt  = dist_r + 20'(len_cur_r - link_len_r);
        state_nxt = S_OUT;
      end
      S_MT: begin
        t_raddr = {ms_r, sym_r};
        if ((ms_r != '0) && !tv) begin
          n_raddr   = ms_r;
          state_nxt = S_ML;
        end else begin
          if (tv) begin
            ms_nxt = tt;
            cmn    = cm_r + 1'b1;
          end
          cm_nxt = cmn;
          if (cmn > best_r) begin
            best_nxt = cmn;
            bpos_nxt = mpos_r;
          end
          if (mpos_r == 16'hFFFF) begin
            sat_nxt = 1'b1;
          end else begin
            mpos_nxt = mpos_r + 1'b1;
          end
          state_nxt = S_OUT;
        end
      end
      S_ML: begin
        ms_nxt    = nlink;
        n_raddr   = nlink;
        state_nxt = S_MLEN;
      end
      S_MLEN: begin
        cm_nxt    = nlen;
        t_raddr   = {ms_r, sym_r};
        state_nxt = S_MT;
      end
      S_OUT: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      epoch_r  <= '0;
      clr_r    <= '0;
      resume_r <= 1'b0;
      cnt_r    <= SW'(1);
      last_r   <= '0;
      tlen_r   <= '0;
      dist_r   <= '0;
      ms_r     <= '0;
      cm_r     <= '0;
      best_r   <= '0;
      bpos_r   <= '0;
      mpos_r   <= '0;
      sat_r    <= 1'b0;
      ovf_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      epoch_r  <= epoch_nxt;
      clr_r    <= clr_nxt;
      resume_r <= resume_nxt;
      cnt_r    <= cnt_nxt;
      last_r   <= last_nxt;
      tlen_r   <= tlen_nxt;
      dist_r   <= dist_nxt;
      ms_r     <= ms_nxt;
      cm_r     <= cm_nxt;
      best_r   <= best_nxt;
      bpos_r   <= bpos_nxt;
      mpos_r   <= mpos_nxt;
      sat_r    <= sat_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sym_r      <= sym_nxt;
    p_r        <= p_nxt;
    cur_r      <= cur_nxt;
    cl_r       <= cl_nxt;
    q_r        <= q_nxt;
    len_cur_r  <= len_cur_nxt;
    len_p_r    <= len_p_nxt;
    len_q_r    <= len_q_nxt;
    link_cur_r <= link_cur_nxt;
    link_len_r <= link_len_nxt;
    k_r        <= k_nxt;
  end

`ifndef SYNTHESIS
  a_epoch_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_CLEAR) |-> (epoch_r != '0))
    else $error("epoch zero outside clearing pass");

  a_match_le_best: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (cm_r <= best_r))
    else $error("current match above best");

  a_text_cap: assert property (@(posedge clk) disable iff (!rst_n)
    tlen_r <= LW'(MAX_TEXT))
    else $error("text length above capacity");

  a_clone_is_newest: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CP) |-> (cl_r == SW'(cnt_r - 1'b1)))
    else $error("clone index not newest state");

  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res_take) |=> (state_r == S_OUT) && $stable(dist_r) && $stable(cm_r))
    else $error("result changed before taken");
`endif

endmodule

[sv/suffix_automaton_lcs_engine_unit.sv]
// Top level of the suffix automaton engine: core sequencer plus result register.
// Depends on sae_pkg and sae_core.
//
//   channel  ports                        transaction
//   in       in_valid/in_ready/in_data    kind, symbol, first
//   out      out_valid/out_ready/out_data counts, match lengths, overflow
//
// Extend: walks suffix links, and per clone copies a row of 2^SYMBOL_BITS
// transitions through the transition memory port.
// Match: follows suffix links on a mismatch.
// After reset, and on every 15th new text, a clearing pass over all
// 2^(log2(2*MAX_TEXT)+SYMBOL_BITS) transition entries holds in_ready low.
// A result waits in the output register while the next transaction is taken.
module suffix_automaton_lcs_engine_unit #(
  parameter int MAX_TEXT    = sae_pkg::DEF_MAX_TEXT,
  parameter int SYMBOL_BITS = sae_pkg::DEF_SYMBOL_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sae_pkg::sae_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output sae_pkg::sae_out_t out_data
);
  import sae_pkg::*;

  logic     res_valid;
  logic     res_take;
  sae_out_t res_data;
  logic     out_valid_r;
  sae_out_t out_data_r;

  sae_core #(.MAX_TEXT(MAX_TEXT), .SYMBOL_BITS(SYMBOL_BITS)) u_core (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .res_valid(res_valid), .res_take(res_take), .res_data(res_data)
  );

  assign res_take = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res_valid) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
